>>> src/tae_pkg.sv
// shared types and constants for the thumb arithmetic execute unit
`timescale 1ns / 1ps

package tae_pkg;

    localparam int WORD_W    = 32;
    localparam int REG_COUNT = 15;
    localparam int IDX_W     = 4;
    localparam int COST_W    = 6;

    localparam logic [IDX_W-1:0]  PC_INDEX        = 4'd15;
    localparam logic [IDX_W-1:0]  SP_INDEX        = 4'd13;
    localparam logic [WORD_W-1:0] WORD_ALIGN_MASK = 32'hFFFF_FFFC;
    localparam logic [COST_W-1:0] COST_SINGLE     = 6'd1;
    localparam logic [COST_W-1:0] COST_PC_WRITE   = 6'd2;
    localparam logic [COST_W-1:0] COST_MULTIPLY   = 6'd32;

    typedef enum logic [3:0] {
        OP_ADCS    = 4'd0,
        OP_ADDS_I3 = 4'd1,
        OP_ADDS_I8 = 4'd2,
        OP_ADDS_R  = 4'd3,
        OP_ADD_R   = 4'd4,
        OP_ADD_SP  = 4'd5,
        OP_ADR     = 4'd6,
        OP_SUBS_I3 = 4'd7,
        OP_SUBS_I8 = 4'd8,
        OP_SUBS    = 4'd9,
        OP_SUB_SP  = 4'd10,
        OP_SBCS    = 4'd11,
        OP_RSBS    = 4'd12,
        OP_MULS    = 4'd13
    } t_op;

    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } t_flags;

    typedef struct packed {
        logic [WORD_W-1:0] write_value;
        logic [IDX_W-1:0]  written_index;
        logic              reg_written;
        logic              pc_written;
        t_flags            flags;
        logic [COST_W-1:0] cycle_cost;
        logic              fault;
    } t_result;

endpackage

>>> src/tae_ram.sv
// generic ram, one write port, two registered read ports
`timescale 1ns / 1ps

module tae_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 15,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr_a,
    input  logic [AW-1:0]    i_rd_addr_b,
    output logic [WIDTH-1:0] o_rd_data_a,
    output logic [WIDTH-1:0] o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

>>> src/tae_exec.sv
// combinational execute: operand select, adder, multiplier, flags and write-back info
`timescale 1ns / 1ps

module tae_exec (
    input  logic [3:0]                  i_op,
    input  logic [tae_pkg::IDX_W-1:0]   i_dest_index,
    input  logic [tae_pkg::IDX_W-1:0]   i_second_index,
    input  logic [7:0]                  i_immediate,
    input  logic [tae_pkg::WORD_W-1:0]  i_pc_value,
    input  logic [tae_pkg::WORD_W-1:0]  i_a_val,
    input  logic [tae_pkg::WORD_W-1:0]  i_b_val,
    input  tae_pkg::t_flags             i_flags,
    output tae_pkg::t_result            o_result
);

    logic [tae_pkg::WORD_W-1:0] a;
    logic [tae_pkg::WORD_W-1:0] b;
    logic                       cin;
    logic [tae_pkg::WORD_W:0]   sum;
    logic [tae_pkg::WORD_W-1:0] prod;
    logic [tae_pkg::WORD_W-1:0] r;
    logic [tae_pkg::WORD_W-1:0] imm_w;
    logic [tae_pkg::WORD_W-1:0] imm_x4;
    logic [tae_pkg::IDX_W-1:0]  dst;
    logic                       does_write;
    logic                       set_all;
    logic                       set_nz;
    logic                       fault;
    logic                       ovf;

    assign imm_w  = {24'd0, i_immediate};
    assign imm_x4 = {22'd0, i_immediate, 2'b00};

    always_comb begin
        a          = '0;
        b          = '0;
        cin        = 1'b0;
        dst        = i_dest_index;
        does_write = 1'b1;
        set_all    = 1'b1;
        set_nz     = 1'b0;
        fault      = 1'b0;
        unique case (tae_pkg::t_op'(i_op))
            tae_pkg::OP_ADCS: begin
                a = i_a_val; b = i_b_val; cin = i_flags.c;
            end
            tae_pkg::OP_ADDS_I3, tae_pkg::OP_ADDS_I8: begin
                a = i_a_val; b = imm_w;
            end
            tae_pkg::OP_ADDS_R: begin
                a = i_a_val; b = i_b_val;
            end
            tae_pkg::OP_ADD_R: begin
                a = i_a_val; b = i_b_val; set_all = 1'b0;
                // both operands pc: unpredictable, nothing written
                if (i_dest_index == tae_pkg::PC_INDEX &&
                    i_second_index == tae_pkg::PC_INDEX) begin
                    does_write = 1'b0;
                    fault      = 1'b1;
                end
            end
            tae_pkg::OP_ADD_SP: begin
                a = i_a_val; b = imm_x4; set_all = 1'b0;
            end
            tae_pkg::OP_ADR: begin
                a = i_pc_value & tae_pkg::WORD_ALIGN_MASK; b = imm_x4; set_all = 1'b0;
            end
            tae_pkg::OP_SUBS_I3, tae_pkg::OP_SUBS_I8: begin
                a = i_a_val; b = ~imm_w; cin = 1'b1;
            end
            tae_pkg::OP_SUBS: begin
                a = i_a_val; b = ~i_b_val; cin = 1'b1;
            end
            tae_pkg::OP_SUB_SP: begin
                a = i_a_val; b = ~imm_x4; cin = 1'b1; set_all = 1'b0;
                dst = tae_pkg::SP_INDEX;
            end
            tae_pkg::OP_SBCS: begin
                a = i_a_val; b = ~i_b_val; cin = i_flags.c;
            end
            tae_pkg::OP_RSBS: begin
                a = '0; b = ~i_a_val; cin = 1'b1;
            end
            tae_pkg::OP_MULS: begin
                set_all = 1'b0; set_nz = 1'b1;
            end
            default: begin
                does_write = 1'b0; set_all = 1'b0;
            end
        endcase
    end

    assign sum  = {1'b0, a} + {1'b0, b} + {{tae_pkg::WORD_W{1'b0}}, cin};
    assign prod = i_a_val * i_b_val;
    assign r    = (i_op == tae_pkg::OP_MULS) ? prod : sum[tae_pkg::WORD_W-1:0];
    assign ovf  = ((a[31] & b[31] & ~r[31]) | (~a[31] & ~b[31] & r[31]));

    always_comb begin
        o_result             = '0;
        o_result.cycle_cost  = tae_pkg::COST_SINGLE;
        o_result.fault       = fault;
        o_result.flags       = i_flags;
        if (does_write) begin
            if (set_all) begin
                o_result.flags = '{n: r[31], z: (r == '0), c: sum[tae_pkg::WORD_W], v: ovf};
            end else if (set_nz) begin
                o_result.flags.n = r[31];
                o_result.flags.z = (r == '0);
            end
            o_result.written_index = dst;
            if (dst == tae_pkg::PC_INDEX) begin
                o_result.write_value = {r[tae_pkg::WORD_W-1:1], 1'b0};
                o_result.pc_written  = 1'b1;
                o_result.cycle_cost  = tae_pkg::COST_PC_WRITE;
            end else begin
                o_result.write_value = r;
                o_result.reg_written = 1'b1;
            end
            if (i_op == tae_pkg::OP_MULS) begin
                o_result.cycle_cost = tae_pkg::COST_MULTIPLY;
            end
        end
    end

endmodule

>>> src/thumb_arith_execute_unit.sv
// top level: input stage, register file ram with bypass, flags and output register
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------------
//  in      | input     | i_in_valid / o_in_stall | op, indexes, immediate, pc value
//  out     | output    | o_out_valid / i_out_stall | value, index, write bits, nzcv, cost, fault
//
// one word per cycle sustained while out is not stalled; o_out_valid rises once the word
// has passed the input register (with the registered ram read), then the result register;
// the rate is set by the single adder/multiplier pass between those registers
// reset clears the flags, the register file valid bits and both valid stages;
// an entry never written since reset reads as zero
// a stall on out holds the result register and backs up into o_in_stall only
// when both stages are full
`timescale 1ns / 1ps

module thumb_arith_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_op,
    input  logic [3:0]  i_dest_index,
    input  logic [3:0]  i_first_index,
    input  logic [3:0]  i_second_index,
    input  logic [7:0]  i_immediate,
    input  logic [31:0] i_pc_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_write_value,
    output logic [3:0]  o_written_index,
    output logic        o_reg_written,
    output logic        o_pc_written,
    output logic        o_neg_flag,
    output logic        o_zero_flag,
    output logic        o_carry_flag,
    output logic        o_overflow_flag,
    output logic [5:0]  o_cycle_cost,
    output logic        o_fault
);

    localparam int IW = tae_pkg::IDX_W;
    localparam int WW = tae_pkg::WORD_W;

    // input stage
    logic          r_s1_vld;
    logic [3:0]    r_op;
    logic [IW-1:0] r_rd;
    logic [IW-1:0] r_rm;
    logic [7:0]    r_imm;
    logic [WW-1:0] r_pc;
    logic [IW-1:0] r_addr_a;
    logic          r_a_vld;
    logic          r_b_vld;
    // write that landed at the same edge as the ram read
    logic          r_byp_en;
    logic [IW-1:0] r_byp_idx;
    logic [WW-1:0] r_byp_data;

    logic [tae_pkg::REG_COUNT-1:0] r_reg_vld;
    tae_pkg::t_flags  r_flags;
    logic             r_out_vld;
    tae_pkg::t_result r_out;

    logic             in_accept;
    logic             advance;
    logic [IW-1:0]    n_addr_a;
    logic [WW-1:0]    ram_a;
    logic [WW-1:0]    ram_b;
    logic [WW-1:0]    reg_a;
    logic [WW-1:0]    reg_b;
    logic [WW-1:0]    a_val;
    logic [WW-1:0]    b_val;
    logic             wr_en;
    tae_pkg::t_result result;

    assign advance    = r_s1_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_s1_vld && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign wr_en      = advance && result.reg_written;

    // first read port: rn, rd or sp depending on the op
    always_comb begin
        priority if (i_op == tae_pkg::OP_ADD_SP || i_op == tae_pkg::OP_SUB_SP) begin
            n_addr_a = tae_pkg::SP_INDEX;
        end else if (i_op == tae_pkg::OP_ADDS_I3 || i_op == tae_pkg::OP_ADDS_R ||
                     i_op == tae_pkg::OP_SUBS_I3 || i_op == tae_pkg::OP_SUBS ||
                     i_op == tae_pkg::OP_RSBS) begin
            n_addr_a = i_first_index;
        end else begin
            n_addr_a = i_dest_index;
        end
    end

    tae_ram #(
        .WIDTH (WW),
        .DEPTH (tae_pkg::REG_COUNT),
        .AW    (IW)
    ) u_regs (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (result.written_index),
        .i_wr_data   (result.write_value),
        .i_rd_en     (in_accept),
        .i_rd_addr_a (n_addr_a),
        .i_rd_addr_b (i_second_index),
        .o_rd_data_a (ram_a),
        .o_rd_data_b (ram_b)
    );

    always_comb begin
        if (r_byp_en && r_byp_idx == r_addr_a) begin
            reg_a = r_byp_data;
        end else begin
            reg_a = r_a_vld ? ram_a : '0;
        end
        if (r_byp_en && r_byp_idx == r_rm) begin
            reg_b = r_byp_data;
        end else begin
            reg_b = r_b_vld ? ram_b : '0;
        end
        a_val = (r_addr_a == tae_pkg::PC_INDEX) ? r_pc : reg_a;
        b_val = (r_rm == tae_pkg::PC_INDEX) ? r_pc : reg_b;
    end

    tae_exec u_exec (
        .i_op           (r_op),
        .i_dest_index   (r_rd),
        .i_second_index (r_rm),
        .i_immediate    (r_imm),
        .i_pc_value     (r_pc),
        .i_a_val        (a_val),
        .i_b_val        (b_val),
        .i_flags        (r_flags),
        .o_result       (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_byp_en  <= 1'b0;
            r_reg_vld <= '0;
            r_flags   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_vld <= 1'b1;
                r_byp_en <= wr_en;
            end else if (advance) begin
                r_s1_vld <= 1'b0;
            end
            if (advance) begin
                r_flags   <= result.flags;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (wr_en) begin
                r_reg_vld[result.written_index] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op       <= i_op;
            r_rd       <= i_dest_index;
            r_rm       <= i_second_index;
            r_imm      <= i_immediate;
            r_pc       <= i_pc_value;
            r_addr_a   <= n_addr_a;
            r_a_vld    <= r_reg_vld[n_addr_a];
            r_b_vld    <= r_reg_vld[i_second_index];
            r_byp_idx  <= result.written_index;
            r_byp_data <= result.write_value;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_write_value   = r_out.write_value;
    assign o_written_index = r_out.written_index;
    assign o_reg_written   = r_out.reg_written;
    assign o_pc_written    = r_out.pc_written;
    assign o_neg_flag      = r_out.flags.n;
    assign o_zero_flag     = r_out.flags.z;
    assign o_carry_flag    = r_out.flags.c;
    assign o_overflow_flag = r_out.flags.v;
    assign o_cycle_cost    = r_out.cycle_cost;
    assign o_fault         = r_out.fault;

endmodule

>>> src/tae_checker.sv
// port-level checks on the execute unit result channel, bound to the top level
`timescale 1ns / 1ps

module tae_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_write_value,
    input logic [3:0]  o_written_index,
    input logic        o_reg_written,
    input logic        o_pc_written,
    input logic [5:0]  o_cycle_cost,
    input logic        o_fault
);

    // a stalled word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // faulting add writes nothing and reports cost COST_SINGLE
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_fault |-> !o_reg_written && !o_pc_written &&
        o_write_value == 32'd0 && o_cycle_cost == tae_pkg::COST_SINGLE)
        else $error("faulting word shows a write");

    // pc write goes to index fifteen, halfword aligned, never also a file write
    a_pc_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_pc_written |-> o_written_index == tae_pkg::PC_INDEX &&
        !o_write_value[0] && !o_reg_written &&
        (o_cycle_cost == tae_pkg::COST_PC_WRITE || o_cycle_cost == tae_pkg::COST_MULTIPLY))
        else $error("bad pc write word");

    // file writes never target index fifteen and never fault
    a_reg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_reg_written |-> o_written_index != tae_pkg::PC_INDEX && !o_fault)
        else $error("bad register write word");

endmodule

bind thumb_arith_execute_unit tae_checker u_tae_checker (.*);
